// ----- rtl/fcct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcct_pkg: shared types and constants for the cluster chain table
// Request codes, status codes, sequencer states and the result bundle
// handed from the sequencer to the top level.
// ----------------------------------------------------------------------------
package fcct_pkg;

   // default number of table entries
   localparam int TABLE_ENTRIES_DEFAULT = 2048;

   // field widths
   localparam int LINK_W = 32;
   localparam int INDEX_W = 16;
   localparam int REQ_W = 3;
   localparam int FDC_W = 8;
   localparam int CIU_W = 12;

   // register reset values
   localparam logic [FDC_W-1:0] FDC_RESET = 8'd4;
   localparam logic [CIU_W-1:0] CIU_RESET = 12'd2048;

   // configuration register indexes
   localparam logic CSR_FIRST_DATA_CLUSTER = 1'b0;
   localparam logic CSR_CLUSTERS_IN_USE = 1'b1;

   // request codes
   localparam logic [REQ_W-1:0] REQ_READ = 3'd0;
   localparam logic [REQ_W-1:0] REQ_SET = 3'd1;
   localparam logic [REQ_W-1:0] REQ_MARK = 3'd2;
   localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd3;
   localparam logic [REQ_W-1:0] REQ_ALLOC_MARK = 3'd4;

   // link values
   localparam logic [LINK_W-1:0] LINK_FREE = '0;
   localparam logic [LINK_W-1:0] LINK_END = '1;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_FULL = 2'd1,
      ST_LOOP = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_CLEAR,
      S_WRITE,
      S_READ,
      S_READ_WAIT,
      S_SCAN,
      S_DONE
   } state_type;

   // finished transaction from the sequencer
   typedef struct packed {
      logic valid;
      status_type status;
      logic [LINK_W-1:0] value;
   } seq_done_type;

endpackage

// ----- rtl/fcct_link_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcct_link_ram: link table storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fcct_link_ram #(
   parameter int DEPTH = fcct_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int AW = $clog2(DEPTH)
) (
   input  logic clock,
   input  logic we,
   input  logic [AW-1:0] waddr,
   input  logic [fcct_pkg::LINK_W-1:0] wdata,
   input  logic re,
   input  logic [AW-1:0] raddr,
   output logic [fcct_pkg::LINK_W-1:0] rdata
);
   import fcct_pkg::*;

   logic [LINK_W-1:0] link_mem_ff [DEPTH];
   logic [LINK_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         link_mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= link_mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/fcct_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcct_sequencer: request sequencer and scan unit
// Decodes one request, then walks the table through the RAM write and read ports:
// clear sweeps, single reads and writes, and the first-fit scan that tests
// one entry per cycle for zero.
// ----------------------------------------------------------------------------
module fcct_sequencer #(
   parameter int TABLE_ENTRIES = fcct_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int AW = $clog2(TABLE_ENTRIES),
   parameter int CW = $clog2(TABLE_ENTRIES + 1)
) (
   input  logic clock,
   input  logic reset,
   // request
   input  logic req_valid,
   output logic req_ready,
   input  logic [fcct_pkg::REQ_W-1:0] req_type,
   input  logic [fcct_pkg::INDEX_W-1:0] cluster_index,
   input  logic [fcct_pkg::LINK_W-1:0] link_value,
   input  logic clear_all,
   // configuration
   input  logic [fcct_pkg::FDC_W-1:0] first_data_cluster,
   input  logic [CW-1:0] active_count,
   // result
   output fcct_pkg::seq_done_type done,
   input  logic slot_free,
   // table port
   output logic ram_we,
   output logic [AW-1:0] ram_waddr,
   output logic [fcct_pkg::LINK_W-1:0] ram_wdata,
   output logic ram_re,
   output logic [AW-1:0] ram_raddr,
   input  logic [fcct_pkg::LINK_W-1:0] ram_rdata
);
   import fcct_pkg::*;

   localparam int LW = (CW > INDEX_W) ? CW : INDEX_W;
   localparam logic [CW-1:0] LAST_ENTRY = CW'(TABLE_ENTRIES - 1);

   state_type state_ff, state_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic chk_valid_ff, chk_valid_in;
   logic [CW-1:0] chk_addr_ff, chk_addr_in;
   logic [AW-1:0] off_ff, off_in;
   logic [LINK_W-1:0] wdata_ff, wdata_in;
   logic mark_ff, mark_in;
   status_type status_ff, status_in;
   logic [LINK_W-1:0] value_ff, value_in;

   logic accept;
   logic [INDEX_W-1:0] off_full;
   logic in_range;
   logic self_loop;
   logic range_empty;
   logic found;
   logic scan_last;

   assign accept = req_valid && req_ready;

   // index decode: data range and self loop
   always_comb begin
      off_full = cluster_index - INDEX_W'(first_data_cluster);
      in_range = (cluster_index >= INDEX_W'(first_data_cluster)) &&
                 (LW'(off_full) < LW'(active_count));
      self_loop = (link_value == LINK_W'(cluster_index));
      range_empty = (active_count == '0);
   end

   // scan compare on the entry read last cycle
   always_comb begin
      found = chk_valid_ff && (ram_rdata == LINK_FREE);
      scan_last = chk_valid_ff && ((chk_addr_ff + CW'(1)) == active_count);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: begin
            if (ptr_ff == LAST_ENTRY) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               if (clear_all) begin
                  state_in = S_CLEAR;
               end else begin
                  case (req_type) inside
                     REQ_READ: state_in = in_range ? S_READ : S_DONE;
                     REQ_SET: state_in = (in_range && !self_loop) ? S_WRITE : S_DONE;
                     REQ_MARK: state_in = in_range ? S_WRITE : S_DONE;
                     REQ_ALLOC, REQ_ALLOC_MARK: state_in = range_empty ? S_DONE : S_SCAN;
                     default: state_in = S_DONE;
                  endcase
               end
            end
         end
         S_CLEAR: begin
            if (ptr_ff == LAST_ENTRY) state_in = S_DONE;
         end
         S_WRITE: state_in = S_DONE;
         S_READ: state_in = S_READ_WAIT;
         S_READ_WAIT: state_in = S_DONE;
         S_SCAN: begin
            if (found) state_in = mark_ff ? S_WRITE : S_DONE;
            else if (scan_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs: table port, handshake and result
   always_comb begin
      ram_we = 1'b0;
      ram_waddr = ptr_ff[AW-1:0];
      ram_wdata = LINK_FREE;
      ram_re = 1'b0;
      ram_raddr = ptr_ff[AW-1:0];
      req_ready = 1'b0;
      done.valid = 1'b0;
      done.status = status_ff;
      done.value = value_ff;
      unique case (state_ff)
         S_INIT, S_CLEAR: ram_we = 1'b1;
         S_IDLE: req_ready = 1'b1;
         S_WRITE: begin
            ram_we = 1'b1;
            ram_waddr = off_ff;
            ram_wdata = wdata_ff;
         end
         S_READ: begin
            ram_re = 1'b1;
            ram_raddr = off_ff;
         end
         S_SCAN: ram_re = 1'b1;
         S_DONE: done.valid = 1'b1;
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      ptr_in = ptr_ff;
      chk_valid_in = chk_valid_ff;
      chk_addr_in = chk_addr_ff;
      off_in = off_ff;
      wdata_in = wdata_ff;
      mark_in = mark_ff;
      status_in = status_ff;
      value_in = value_ff;
      case (state_ff)
         S_INIT, S_CLEAR: ptr_in = ptr_ff + CW'(1);
         S_IDLE: begin
            if (accept) begin
               ptr_in = '0;
               chk_valid_in = 1'b0;
               off_in = off_full[AW-1:0];
               wdata_in = (req_type == REQ_SET) ? link_value : LINK_END;
               mark_in = (req_type == REQ_ALLOC_MARK);
               value_in = '0;
               status_in = ST_OK;
               if (!clear_all) begin
                  case (req_type) inside
                     REQ_READ, REQ_MARK: begin
                        if (!in_range) status_in = ST_RANGE;
                     end
                     REQ_SET: begin
                        if (!in_range) status_in = ST_RANGE;
                        else if (self_loop) status_in = ST_LOOP;
                     end
                     REQ_ALLOC, REQ_ALLOC_MARK: begin
                        if (range_empty) status_in = ST_FULL;
                     end
                     default: ;
                  endcase
               end
            end
         end
         S_READ_WAIT: value_in = ram_rdata;
         S_SCAN: begin
            ptr_in = ptr_ff + CW'(1);
            chk_valid_in = 1'b1;
            chk_addr_in = ptr_ff;
            if (found) begin
               value_in = LINK_W'(first_data_cluster) + LINK_W'(chk_addr_ff);
               off_in = chk_addr_ff[AW-1:0];
               wdata_in = LINK_END;
            end else if (scan_last) begin
               status_in = ST_FULL;
               value_in = '0;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         ptr_ff <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff <= ptr_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      chk_addr_ff <= chk_addr_in;
      off_ff <= off_in;
      wdata_ff <= wdata_in;
      mark_ff <= mark_in;
      status_ff <= status_in;
      value_ff <= value_in;
   end

`ifndef SYNTHESIS
   // a clear request goes straight to the sweep
   assert property (@(posedge clock) disable iff (reset)
      (accept && clear_all) |=> (state_ff == S_CLEAR))
      else $error("clear request did not start the sweep");

   // the scan never checks an entry outside the active range
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && chk_valid_ff) |-> (chk_addr_ff < active_count))
      else $error("scan ran past the active range");

   // the scan never writes the table
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !ram_we)
      else $error("table write during scan");

   // a finished result waits for the output slot
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !slot_free) |=> (state_ff == S_DONE && $stable(value_ff)))
      else $error("result dropped while output slot busy");
`endif

endmodule

// ----- rtl/fat_cluster_chain_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_cluster_chain_table: cluster link table with first-fit allocation
// Holds one 32-bit link per data cluster, serves read, set, mark-end,
// allocate and clear requests through one sequencer and one table RAM.
//
//   channel   dir  handshake             payload
//   req_*     in   req_tvalid/tready     tdata: cluster_index, link_value
//                                        tuser: req_type, clear_all
//   rsp_*     out  rsp_tvalid/tready     tdata: result_value; tuser: status
//   csr_*     in   csr_we                csr_index, csr_wdata
//
// Allocate scans the active entries from offset 0 for the first free one
// (one entry per cycle through the RAM read port, then a write with mark);
// with no free active entry it reports disk full. Clear sweeps every entry.
// After reset a clearing pass over all TABLE_ENTRIES entries runs before
// req_tready rises; csr writes are taken throughout.
// One request at a time; the next is taken while a result waits in the
// output register, and a full output register stalls the sequencer.
// ----------------------------------------------------------------------------
module fat_cluster_chain_table #(
   parameter int TABLE_ENTRIES = fcct_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [47:0] req_tdata,   // [15:0] cluster_index, [47:16] link_value
   input  logic [3:0] req_tuser,    // [2:0] req_type, [3] clear_all
   // result channel
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] result_value
   output logic [1:0] rsp_tuser,    // [1:0] status
   // configuration
   input  logic csr_we,
   input  logic csr_index,
   input  logic [fcct_pkg::CIU_W-1:0] csr_wdata
);
   import fcct_pkg::*;

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int CMPW = (CW > CIU_W) ? CW : CIU_W;

   logic [FDC_W-1:0] fdc_ff, fdc_in;
   logic [CIU_W-1:0] ciu_ff, ciu_in;
   logic [CW-1:0] active_count;

   logic rsp_valid_ff, rsp_valid_in;
   logic [LINK_W-1:0] rsp_value_ff, rsp_value_in;
   status_type rsp_status_ff, rsp_status_in;

   seq_done_type done;
   logic slot_free;

   logic ram_we;
   logic [AW-1:0] ram_waddr;
   logic [LINK_W-1:0] ram_wdata;
   logic ram_re;
   logic [AW-1:0] ram_raddr;
   logic [LINK_W-1:0] ram_rdata;

   // configuration registers
   always_comb begin
      fdc_in = fdc_ff;
      ciu_in = ciu_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST_DATA_CLUSTER: fdc_in = csr_wdata[FDC_W-1:0];
            CSR_CLUSTERS_IN_USE: ciu_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fdc_ff <= FDC_RESET;
         ciu_ff <= CIU_RESET;
      end else begin
         fdc_ff <= fdc_in;
         ciu_ff <= ciu_in;
      end
   end

   // active entries: clusters_in_use capped at the table size
   assign active_count = (CMPW'(ciu_ff) > CMPW'(TABLE_ENTRIES)) ?
                         CW'(TABLE_ENTRIES) : CW'(ciu_ff);

   // output register
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (done.valid && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = done.value;
         rsp_status_in = done.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_value_ff;
   assign rsp_tuser = rsp_status_ff;

   fcct_sequencer #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .AW(AW),
      .CW(CW)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_type(req_tuser[REQ_W-1:0]),
      .cluster_index(req_tdata[INDEX_W-1:0]),
      .link_value(req_tdata[INDEX_W+LINK_W-1:INDEX_W]),
      .clear_all(req_tuser[REQ_W]),
      .first_data_cluster(fdc_ff),
      .active_count(active_count),
      .done(done),
      .slot_free(slot_free),
      .ram_we(ram_we),
      .ram_waddr(ram_waddr),
      .ram_wdata(ram_wdata),
      .ram_re(ram_re),
      .ram_raddr(ram_raddr),
      .ram_rdata(ram_rdata)
   );

   fcct_link_ram #(
      .DEPTH(TABLE_ENTRIES),
      .AW(AW)
   ) u_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re(ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

endmodule

// ----- sim/tb_fat_cluster_chain_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fat_cluster_chain_table: self-checking bench for the cluster chain table
// Drives read, set, mark-end, allocate, allocate-and-mark, clear and unknown
// requests over the request stream under several register settings, tracks
// the link table alongside the block and compares every response field by
// field against the tracked result, in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_fat_cluster_chain_table;
   import fcct_pkg::*;

   localparam int TABLE_N = TABLE_ENTRIES_DEFAULT;
   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int HOLD_CYCLES = 150;
   localparam int TAIL_CYCLES = TABLE_N + 16;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 33;

   typedef struct packed {
      status_type status;
      logic [LINK_W-1:0] value;
   } table_rsp_type;

   // tracks the link table and the register copies, queues predicted responses
   class chain_table_tracker;
      logic [LINK_W-1:0] links [TABLE_N];
      logic [FDC_W-1:0] first_cluster;
      logic [CIU_W-1:0] clusters_used;
      table_rsp_type pending_rsp [$];
      int errors;

      function new();
         foreach (links[i]) links[i] = LINK_FREE;
         first_cluster = FDC_RESET;
         clusters_used = CIU_RESET;
         errors = 0;
      endfunction

      function void write_register(logic idx, logic [CIU_W-1:0] data);
         if (idx == CSR_FIRST_DATA_CLUSTER)
            first_cluster = data[FDC_W-1:0];
         else
            clusters_used = data;
      endfunction

      // apply one accepted request to the tracked table and queue its response
      function void note_request(logic [REQ_W-1:0] kind, logic [INDEX_W-1:0] idx,
                                 logic [LINK_W-1:0] val, logic clr);
         table_rsp_type rsp;
         int active;
         int unsigned off;
         bit found;
         active = (clusters_used > TABLE_N) ? TABLE_N : int'(clusters_used);
         rsp.status = ST_OK;
         rsp.value = '0;
         if (clr) begin
            foreach (links[i]) links[i] = LINK_FREE;
         end else if (kind <= REQ_MARK) begin
            off = int'(idx) - int'(first_cluster);
            if (idx < first_cluster || off >= active) begin
               rsp.status = ST_RANGE;
            end else if (kind == REQ_READ) begin
               rsp.value = links[off];
            end else if (kind == REQ_SET) begin
               if (val == {16'h0, idx})
                  rsp.status = ST_LOOP;
               else
                  links[off] = val;
            end else begin
               links[off] = LINK_END;
            end
         end else if (kind <= REQ_ALLOC_MARK) begin
            // first fit over the active entries
            found = 0;
            off = 0;
            for (int i = 0; i < active && !found; i++) begin
               if (links[i] == LINK_FREE) begin
                  found = 1;
                  off = i;
               end
            end
            if (!found) begin
               rsp.status = ST_FULL;
            end else begin
               rsp.value = 32'(first_cluster) + off;
               if (kind == REQ_ALLOC_MARK) links[off] = LINK_END;
            end
         end
         pending_rsp = {pending_rsp, rsp};
      endfunction

      function void check_result(logic [1:0] status, logic [LINK_W-1:0] value);
         table_rsp_type rsp;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response, status %0d value %h", $time, status, value);
            errors++;
         end else begin
            rsp = pending_rsp.pop_front();
            if (status !== rsp.status || value !== rsp.value) begin
               $display({"%0t: response mismatch, expected status %0d value %h, ",
                         "actual status %0d value %h"},
                        $time, rsp.status, rsp.value, status, value);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [47:0] req_tdata;    // [15:0] cluster_index, [47:16] link_value
   logic [3:0] req_tuser;     // [2:0] req_type, [3] clear_all
   logic rsp_tvalid;
   logic rsp_tready;
   logic [31:0] rsp_tdata;    // [31:0] result_value
   logic [1:0] rsp_tuser;     // [1:0] status
   logic csr_we;
   logic csr_index;
   logic [CIU_W-1:0] csr_wdata;

   chain_table_tracker sb;
   bit idling_on = 1;
   bit hold_request = 0;
   int hold_left = 0;
   int rx_idle_left = 0;
   int cycle_count = 0;

   fat_cluster_chain_table dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // response side: random ready bursts, plus one long hold on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rx_idle_left > 0) begin
         rx_idle_left--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rx_idle_left = $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         sb.check_result(rsp_tuser, rsp_tdata);
   end

   // offer one request, optionally after a short gap, and wait for acceptance
   task automatic send_request(logic [REQ_W-1:0] kind, logic [INDEX_W-1:0] idx,
                               logic [LINK_W-1:0] val, logic clr);
      int gap;
      gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {val, idx};
      req_tuser <= {clr, kind};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(kind, idx, val, clr);
   endtask

   // stop offering and wait until every queued response has come back
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [CIU_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_register(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly in-range traffic that builds and walks chains, plus edges and noise
   task automatic send_random_request();
      logic [REQ_W-1:0] kind;
      logic [INDEX_W-1:0] idx;
      logic [LINK_W-1:0] val;
      logic clr;
      int act;
      int fdc;
      int r;
      act = (sb.clusters_used > TABLE_N) ? TABLE_N : int'(sb.clusters_used);
      fdc = int'(sb.first_cluster);
      clr = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         clr = 1'b1;
         kind = REQ_W'($urandom);
      end else if (r < 6) kind = REQ_W'($urandom_range(5, 7));
      else if (r < 30) kind = REQ_READ;
      else if (r < 50) kind = REQ_SET;
      else if (r < 60) kind = REQ_MARK;
      else if (r < 72) kind = REQ_ALLOC;
      else kind = REQ_ALLOC_MARK;

      r = $urandom_range(0, 9);
      if (r < 8 && act > 0)
         idx = INDEX_W'(fdc + $urandom_range(0, act - 1));
      else if (r == 8)
         idx = $urandom_range(0, 1) ? INDEX_W'(fdc - 1) : INDEX_W'(fdc + act);
      else
         idx = INDEX_W'($urandom);

      r = $urandom_range(0, 9);
      if (r < 5) val = LINK_W'(fdc + $urandom_range(0, (act > 0) ? act - 1 : 0));
      else if (r == 5) val = LINK_END;
      else if (r == 6) val = {16'h0, idx};
      else if (r == 7) val = LINK_FREE;
      else val = $urandom;

      send_request(kind, idx, val, clr);
   endtask

   initial begin
      logic [FDC_W-1:0] fdc;
      logic [CIU_W-1:0] ciu;
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: range edges, links, self loop, repeated allocate, unknown codes
      send_request(REQ_READ, 16'd3, $urandom, 1'b0);
      send_request(REQ_READ, 16'd4, $urandom, 1'b0);
      send_request(REQ_READ, 16'd2051, $urandom, 1'b0);
      send_request(REQ_READ, 16'd2052, $urandom, 1'b0);
      send_request(REQ_READ, 16'hFFFF, $urandom, 1'b0);
      send_request(REQ_SET, 16'd4, 32'd5, 1'b0);
      send_request(REQ_READ, 16'd4, 32'd0, 1'b0);
      send_request(REQ_SET, 16'd5, 32'd5, 1'b0);
      send_request(REQ_SET, 16'd2051, LINK_END, 1'b0);
      send_request(REQ_SET, 16'd2052, 32'd1, 1'b0);
      send_request(REQ_MARK, 16'd6, $urandom, 1'b0);
      send_request(REQ_ALLOC, INDEX_W'($urandom), $urandom, 1'b0);
      send_request(REQ_ALLOC, INDEX_W'($urandom), $urandom, 1'b0);
      send_request(REQ_ALLOC_MARK, INDEX_W'($urandom), $urandom, 1'b0);
      send_request(REQ_ALLOC, INDEX_W'($urandom), $urandom, 1'b0);
      send_request(3'd5, INDEX_W'($urandom), $urandom, 1'b0);
      send_request(3'd6, INDEX_W'($urandom), $urandom, 1'b0);
      send_request(3'd7, INDEX_W'($urandom), $urandom, 1'b0);
      send_request(REQ_ALLOC_MARK, INDEX_W'($urandom), $urandom, 1'b1);
      send_request(REQ_READ, 16'd4, 32'd0, 1'b0);

      // empty range
      drain_results();
      write_csr(CSR_CLUSTERS_IN_USE, 12'd0);
      send_request(REQ_READ, 16'd4, 32'd0, 1'b0);
      send_request(REQ_ALLOC_MARK, 16'd0, 32'd0, 1'b0);

      // top first cluster with upper data bits set, two entries, fill to full
      drain_results();
      write_csr(CSR_FIRST_DATA_CLUSTER, 12'hFFF);
      write_csr(CSR_CLUSTERS_IN_USE, 12'd2);
      send_request(REQ_ALLOC_MARK, 16'd0, 32'd0, 1'b0);
      send_request(REQ_ALLOC_MARK, 16'd0, 32'd0, 1'b0);
      send_request(REQ_ALLOC_MARK, 16'd0, 32'd0, 1'b0);
      send_request(REQ_ALLOC, 16'd0, 32'd0, 1'b0);
      send_request(REQ_MARK, 16'd254, 32'd0, 1'b0);
      send_request(REQ_READ, 16'd256, 32'd0, 1'b0);

      // first cluster zero, count above the table size
      drain_results();
      write_csr(CSR_FIRST_DATA_CLUSTER, 12'd0);
      write_csr(CSR_CLUSTERS_IN_USE, 12'hFFF);
      send_request(REQ_READ, 16'd0, 32'd0, 1'b0);
      send_request(REQ_READ, 16'd2047, 32'd0, 1'b0);
      send_request(REQ_READ, 16'd2048, 32'd0, 1'b0);

      // random phases, each under its own register setting
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         case (phase)
            0: begin fdc = 8'd1; ciu = CIU_W'($urandom_range(4, 16)); end
            1: begin fdc = 8'd255; ciu = 12'd2048; end
            2: begin fdc = FDC_W'($urandom_range(1, 255)); ciu = 12'd1; end
            3: begin fdc = FDC_W'($urandom_range(1, 255)); ciu = 12'hFFF; end
            4: begin fdc = 8'd0; ciu = CIU_W'($urandom_range(8, 40)); end
            5: begin fdc = FDC_W'($urandom); ciu = CIU_W'($urandom_range(1, 2048)); end
            6: begin fdc = FDC_W'($urandom); ciu = CIU_W'($urandom_range(2, 24)); end
            default: begin fdc = FDC_W'($urandom); ciu = CIU_W'($urandom_range(8, 64)); end
         endcase
         write_csr(CSR_FIRST_DATA_CLUSTER, {4'($urandom), fdc});
         write_csr(CSR_CLUSTERS_IN_USE, ciu);
         // last phase runs with no idling on either side
         if (phase == PHASES - 1) idling_on = 0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 1 && n == 8) hold_request = 1;
            send_random_request();
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/fcct_pkg.sv
rtl/fcct_link_ram.sv
rtl/fcct_sequencer.sv
rtl/fat_cluster_chain_table.sv
sim/tb_fat_cluster_chain_table.sv
